### src/gpcc_pkg.sv
`timescale 1ns / 1ps
// Package for the grid path collision checker: shared constants, codes and types.
// Used by gpcc_front, gpcc_back and the top level; depends on nothing.
package gpcc_pkg;

  localparam int COORD_BITS = 16;
  localparam int XW         = COORD_BITS + 2;   // cell coordinate incl. footprint offset
  localparam int DW         = COORD_BITS + 1;   // segment delta magnitude
  localparam int DIM_BITS   = 9;
  localparam int RAD_BITS   = 4;
  localparam int IDX_BITS   = 16;
  localparam int VAL_BITS   = 8;
  localparam int CFG_DW     = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
  localparam int QUEUE_DEPTH = 2;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_RADIUS = 15;

  localparam logic [VAL_BITS-1:0] OCCUPIED_VALUE = 8'd100;
  localparam int                  ROW_OFFSET     = 2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  typedef enum logic [1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_ORIGIN_X    = 2'd2,
    REG_ORIGIN_Y    = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_CHECK = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic [DIM_BITS-1:0]          width;
    logic [DIM_BITS-1:0]          height;
    logic signed [COORD_BITS-1:0] origin_x;
    logic signed [COORD_BITS-1:0] origin_y;
  } grid_cfg_t;

  typedef struct packed {
    item_kind_e                   kind;
    logic                         load_ok;
    logic [IDX_BITS-1:0]          cell_index;
    logic                         occupied;
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
    logic signed [COORD_BITS-1:0] x2;
    logic signed [COORD_BITS-1:0] y2;
    logic [RAD_BITS-1:0]          radius;
    logic                         walk_en;
    logic                         y_major;
    logic                         maj_neg;
    logic                         min_neg;
    logic [DW-1:0]                amaj;
    logic [DW-1:0]                amin;
  } item_t;

endpackage

### src/gpcc_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module gpcc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/gpcc_front.sv
`timescale 1ns / 1ps
// Front end: classifies incoming items and holds them in a short queue.
// Depends on gpcc_pkg.
module gpcc_front import gpcc_pkg::*; #(
  parameter int STORE_DEPTH = 65536,
  parameter int MAX_RADIUS  = 15
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic                         command_i,
  input  logic [IDX_BITS-1:0]          cell_index_i,
  input  logic [VAL_BITS-1:0]          cell_value_i,
  input  logic signed [COORD_BITS-1:0] from_x_i,
  input  logic signed [COORD_BITS-1:0] from_y_i,
  input  logic signed [COORD_BITS-1:0] to_x_i,
  input  logic signed [COORD_BITS-1:0] to_y_i,
  input  logic [RAD_BITS-1:0]          radius_i,
  output logic                         q_valid_o,
  output item_t                        q_item_o,
  input  logic                         q_pop_i
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  item_t              entry;
  item_t              queue_q [QUEUE_DEPTH];
  logic [PW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [PW:0]        count_q;
  logic               wr_en, rd_en;
  logic signed [DW-1:0] dx, dy, dxd;
  logic [DW-1:0]      adx, ady;
  logic [RAD_BITS-1:0] rad;

  always_comb begin
    dx  = DW'(to_x_i) - DW'(from_x_i);
    dy  = DW'(to_y_i) - DW'(from_y_i);
    dxd = (dx == '0) ? DW'(1) : dx;
    adx = dxd[DW-1] ? DW'(-dxd) : DW'(dxd);
    ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
    rad = (int'(radius_i) > MAX_RADIUS) ? RAD_BITS'(MAX_RADIUS) : radius_i;

    entry            = '0;
    entry.kind       = (command_i == CMD_CHECK) ? KIND_CHECK : KIND_LOAD;
    entry.load_ok    = (32'(cell_index_i) < STORE_DEPTH);
    entry.cell_index = cell_index_i;
    entry.occupied   = (cell_value_i == OCCUPIED_VALUE);
    entry.x1         = from_x_i;
    entry.y1         = from_y_i;
    entry.x2         = to_x_i;
    entry.y2         = to_y_i;
    entry.radius     = rad;
    entry.y_major    = (ady > adx);
    // With a zero radius the walk tests nothing, so it is skipped.
    entry.walk_en    = (rad != '0) && ((ady > adx) || (dx != '0));
    entry.maj_neg    = (ady > adx) ? dy[DW-1] : dx[DW-1];
    entry.min_neg    = (ady > adx) ? dxd[DW-1] : dy[DW-1];
    entry.amaj       = (ady > adx) ? ady : adx;
    entry.amin       = (ady > adx) ? adx : ady;
  end

  assign full      = (count_q == (PW+1)'(QUEUE_DEPTH));
  assign q_valid_o = (count_q != '0);
  assign q_item_o  = queue_q[rd_ptr_q];
  assign wr_en     = push && !full;
  assign rd_en     = q_pop_i && q_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (int'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= (int'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (PW+1)'(wr_en) - (PW+1)'(rd_en);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      queue_q[wr_ptr_q] <= entry;
    end
  end

endmodule

### src/gpcc_back.sv
`timescale 1ns / 1ps
// Back end: executes loads and walks the cells of a check through the bitmap.
// Depends on gpcc_pkg and gpcc_ram.
module gpcc_back import gpcc_pkg::*; #(
  parameter int STORE_DEPTH = 65536
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  grid_cfg_t cfg_i,
  input  logic      q_valid_i,
  input  item_t     q_item_i,
  output logic      q_pop_o,
  output logic      empty,
  input  logic      pop,
  output logic      path_free_o
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIAM,
    ST_WALK,
    ST_DRAIN
  } st_e;

  st_e                  st_q;
  item_t                item_q;
  logic                 second_q;
  logic [RAD_BITS-1:0]  i_q, j_q;
  logic [1:0]           q_q;
  logic signed [XW-1:0] cx_q, cy_q;
  logic [DW-1:0]        steps_q, rem_q;
  logic [DW:0]          rem_sum;
  logic                 carry;
  logic                 blocked_q;
  logic                 res_valid_q, res_free_q;
  logic                 res_push, pipe_busy;

  logic                 gen_v;
  logic signed [XW-1:0] gen_x, gen_y, off_i, off_j;

  logic                 s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic signed [XW-1:0] s1_x_q, s1_y_q;
  logic signed [XW:0]   rx, ry;
  logic                 inr;
  logic [DIM_BITS-1:0]  s2_rx_q, s2_row_q;
  logic [2*DIM_BITS:0]  lin;
  logic [AW-1:0]        s3_addr_q;
  logic                 ram_we;
  logic                 rdata;

  // Cell generator: diamond footprints around an endpoint, arms along the walk.
  always_comb begin
    off_i = XW'(i_q);
    off_j = XW'(j_q);
    gen_v = (st_q == ST_DIAM) || (st_q == ST_WALK);
    gen_x = cx_q;
    gen_y = cy_q;
    if (st_q == ST_DIAM) begin
      gen_x = q_q[0] ? cx_q - off_i : cx_q + off_i;
      gen_y = q_q[1] ? cy_q - off_j : cy_q + off_j;
    end else begin
      unique case (q_q)
        2'd0: gen_x = cx_q + off_j;
        2'd1: gen_x = cx_q - off_j;
        2'd2: gen_y = cy_q - off_j;
        default: gen_y = cy_q + off_j;
      endcase
    end
  end

  always_comb begin
    rem_sum = (DW+1)'(rem_q) + (DW+1)'(item_q.amin);
    carry   = (rem_sum >= (DW+1)'(item_q.amaj));
  end

  assign pipe_busy = s1_v_q || s2_v_q || s3_v_q || s4_v_q;
  assign res_push  = (st_q == ST_DRAIN) && !pipe_busy && (!res_valid_q || pop);
  assign q_pop_o   = (st_q == ST_IDLE) && q_valid_i;
  assign ram_we    = q_pop_o && (q_item_i.kind == KIND_LOAD) && q_item_i.load_ok;
  assign empty       = !res_valid_q;
  assign path_free_o = res_free_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      item_q      <= '0;
      second_q    <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      q_q         <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      steps_q     <= '0;
      rem_q       <= '0;
      res_valid_q <= 1'b0;
      res_free_q  <= 1'b0;
    end else begin
      if (res_push) begin
        res_valid_q <= 1'b1;
        res_free_q  <= !blocked_q;
      end else if (pop && res_valid_q) begin
        res_valid_q <= 1'b0;
      end

      unique case (st_q)
        ST_IDLE: begin
          if (q_pop_o && (q_item_i.kind == KIND_CHECK)) begin
            item_q   <= q_item_i;
            second_q <= 1'b0;
            i_q      <= '0;
            j_q      <= '0;
            q_q      <= '0;
            cx_q     <= XW'($signed(q_item_i.x1));
            cy_q     <= XW'($signed(q_item_i.y1));
            st_q     <= ST_DIAM;
          end
        end
        ST_DIAM: begin
          q_q <= q_q + 2'd1;
          if (q_q == 2'd3) begin
            if (j_q == item_q.radius - i_q) begin
              if (i_q == item_q.radius) begin
                i_q <= '0;
                if (second_q) begin
                  j_q  <= '0;
                  st_q <= ST_DRAIN;
                end else if (item_q.walk_en) begin
                  // The walk starts at the first endpoint, still held in cx/cy.
                  j_q     <= RAD_BITS'(1);
                  rem_q   <= '0;
                  steps_q <= item_q.amaj;
                  st_q    <= ST_WALK;
                end else begin
                  j_q      <= '0;
                  second_q <= 1'b1;
                  cx_q     <= XW'($signed(item_q.x2));
                  cy_q     <= XW'($signed(item_q.y2));
                end
              end else begin
                j_q <= '0;
                i_q <= i_q + 1'b1;
              end
            end else begin
              j_q <= j_q + 1'b1;
            end
          end
        end
        ST_WALK: begin
          q_q <= q_q + 2'd1;
          if (q_q == 2'd3) begin
            if (j_q == item_q.radius) begin
              if (steps_q == DW'(1)) begin
                j_q      <= '0;
                second_q <= 1'b1;
                cx_q     <= XW'($signed(item_q.x2));
                cy_q     <= XW'($signed(item_q.y2));
                st_q     <= ST_DIAM;
              end else begin
                j_q     <= RAD_BITS'(1);
                steps_q <= steps_q - 1'b1;
                rem_q   <= carry ? DW'(rem_sum - (DW+1)'(item_q.amaj)) : DW'(rem_sum);
                // The major coordinate moves one cell; the minor one moves on a carry.
                if (item_q.y_major) begin
                  cy_q <= item_q.maj_neg ? cy_q - 1'b1 : cy_q + 1'b1;
                  if (carry) begin
                    cx_q <= item_q.min_neg ? cx_q - 1'b1 : cx_q + 1'b1;
                  end
                end else begin
                  cx_q <= item_q.maj_neg ? cx_q - 1'b1 : cx_q + 1'b1;
                  if (carry) begin
                    cy_q <= item_q.min_neg ? cy_q - 1'b1 : cy_q + 1'b1;
                  end
                end
              end
            end else begin
              j_q <= j_q + 1'b1;
            end
          end
        end
        ST_DRAIN: begin
          if (res_push) begin
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // Cell lookup pipeline: bounds test, linear index, bitmap read, accumulate.
  always_comb begin
    rx  = (XW+1)'(s1_x_q) - (XW+1)'($signed(cfg_i.origin_x));
    ry  = (XW+1)'(s1_y_q) - (XW+1)'($signed(cfg_i.origin_y));
    inr = (rx > 0) && (rx < (XW+1)'($signed({1'b0, cfg_i.width}))) &&
          (ry >= (XW+1)'(ROW_OFFSET)) &&
          (ry < (XW+1)'($signed({1'b0, cfg_i.height})));
    lin = (2*DIM_BITS+1)'(s2_row_q) * (2*DIM_BITS+1)'(cfg_i.width) +
          (2*DIM_BITS+1)'(s2_rx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
      s4_v_q    <= 1'b0;
      blocked_q <= 1'b0;
    end else begin
      s1_v_q <= gen_v;
      s2_v_q <= s1_v_q && inr;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      if (q_pop_o) begin
        blocked_q <= 1'b0;
      end else if (s4_v_q && rdata) begin
        blocked_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_x_q    <= gen_x;
    s1_y_q    <= gen_y;
    s2_rx_q   <= rx[DIM_BITS-1:0];
    s2_row_q  <= DIM_BITS'(ry - (XW+1)'(ROW_OFFSET));
    s3_addr_q <= AW'(lin);
  end

  gpcc_ram #(
    .WIDTH(1),
    .DEPTH(STORE_DEPTH)
  ) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(q_item_i.cell_index)),
    .wdata_i(q_item_i.occupied),
    .raddr_i(s3_addr_q),
    .rdata_o(rdata)
  );

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> !pipe_busy)
    else $error("lookup pipeline busy while idle");

  a_write_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (!s3_v_q && !s4_v_q))
    else $error("bitmap write during a pending read");

  a_walk_arm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_WALK) |-> ((j_q != '0) && (j_q <= item_q.radius)))
    else $error("walk arm distance out of range");

  a_diam_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DIAM) |-> ((i_q <= item_q.radius) && (j_q <= item_q.radius - i_q)))
    else $error("diamond offset outside footprint");

endmodule

### src/grid_path_collision_check_unit.sv
`timescale 1ns / 1ps
// Top level of the grid path collision checker: configuration registers and wiring.
// Depends on gpcc_pkg, gpcc_front, gpcc_back and gpcc_ram.
//
// Usage. Items enter through a queue-like port: an item is taken on a clock edge
// with push high and full low. command_i = 0 loads one bitmap cell (cell_index_i,
// cell_value_i; value 100 marks it occupied) and gives no result. command_i = 1
// checks the path from (from_x_i, from_y_i) to (to_x_i, to_y_i) with a clearance
// radius_i and gives one path_free_o result. Results leave through a queue-like
// port: the oldest result is valid while empty is low and is taken with pop.
// Configuration (grid size, origin) is written on the cfg port, which is always ready.
// The user writes it only while no transaction is in flight; the block does not check.
// Timing. A load is written to the bitmap in the same cycle as the execution unit
// takes it from the queue. A check runs to its result before the execution unit takes
// the next item; the lookup pipeline tests one cell per cycle through the single
// bitmap read port. A two-entry queue lets new items arrive while a check runs.
// Reset clears control state and sets a 256 x 256 grid at origin 0,0. The bitmap is
// not cleared, so the user must load every cell before it is checked; the block does
// not enforce it. While a result waits to be taken, the next check holds at its end.
module grid_path_collision_check_unit import gpcc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [CFG_DW-1:0]            cfg_data_i,
  input  logic                         push,
  output logic                         full,
  input  logic                         command_i,
  input  logic [IDX_BITS-1:0]          cell_index_i,
  input  logic [VAL_BITS-1:0]          cell_value_i,
  input  logic signed [COORD_BITS-1:0] from_x_i,
  input  logic signed [COORD_BITS-1:0] from_y_i,
  input  logic signed [COORD_BITS-1:0] to_x_i,
  input  logic signed [COORD_BITS-1:0] to_y_i,
  input  logic [RAD_BITS-1:0]          radius_i,
  output logic                         empty,
  input  logic                         pop,
  output logic                         path_free_o
);

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int RST_WIDTH   = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int RST_HEIGHT  = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

  grid_cfg_t           cfg_q;
  logic [DIM_BITS-1:0] dim_val;
  logic                q_valid, q_pop;
  item_t               q_item;

  assign cfg_ready_o = 1'b1;
  assign dim_val     = cfg_data_i[DIM_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width    <= DIM_BITS'(RST_WIDTH);
      cfg_q.height   <= DIM_BITS'(RST_HEIGHT);
      cfg_q.origin_x <= '0;
      cfg_q.origin_y <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_GRID_WIDTH:
          cfg_q.width <= (int'(dim_val) > MAX_WIDTH) ? DIM_BITS'(MAX_WIDTH) : dim_val;
        REG_GRID_HEIGHT:
          cfg_q.height <= (int'(dim_val) > MAX_HEIGHT) ? DIM_BITS'(MAX_HEIGHT) : dim_val;
        REG_ORIGIN_X: cfg_q.origin_x <= cfg_data_i[COORD_BITS-1:0];
        REG_ORIGIN_Y: cfg_q.origin_y <= cfg_data_i[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  gpcc_front #(
    .STORE_DEPTH(STORE_DEPTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .command_i   (command_i),
    .cell_index_i(cell_index_i),
    .cell_value_i(cell_value_i),
    .from_x_i    (from_x_i),
    .from_y_i    (from_y_i),
    .to_x_i      (to_x_i),
    .to_y_i      (to_y_i),
    .radius_i    (radius_i),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_pop_i     (q_pop)
  );

  gpcc_back #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .path_free_o(path_free_o)
  );

endmodule
